>>> hdl/sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the stereo feedback delay
// Register indexes, field widths, reset values and fixed-point constants.
// ----------------------------------------------------------------------------
package sfd_pkg;

	// sequencer states of one request
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_ADDR,
		ST_WB
	} state_t;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_MS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPREAD_MS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd4;

	// register widths
	localparam int SR_W  = 18;
	localparam int DMS_W = 11;
	localparam int SPR_W = 9;
	localparam int WET_W = 17;
	localparam int FB_W  = 16;

	// register reset values
	localparam logic [SR_W-1:0]  SR_RST  = 18'd48000;
	localparam logic [DMS_W-1:0] DMS_RST = 11'd250;
	localparam logic [SPR_W-1:0] SPR_RST = 9'd0;
	localparam logic [WET_W-1:0] WET_RST = 17'd32768;
	localparam logic [FB_W-1:0]  FB_RST  = 16'd32768;

	// unsigned q.16 gains: wet in q1.16, feedback in q0.16
	localparam int               FRAC_W    = 16;
	localparam int               GAIN_X_W  = 18;
	localparam logic [WET_W-1:0] UNITY_Q16 = 17'd65536;
	localparam logic [15:0]      ROUND_Q16 = 16'h8000;

	// delay time in signed q11.16 ms, never above 2047 ms
	localparam int CD_W  = 28;
	// total delay after spread, clamped at zero
	localparam int TOT_W = 28;

	// ms to samples: floor(total * rate / (1000 * 2^16))
	// the product is shifted by 16 + 3, then divided by 125 through a reciprocal
	localparam int              MS_DIV_SH   = 19;
	localparam int              MS_V_W      = 27;
	localparam int              MS_R_W      = 28;
	localparam logic [MS_R_W-1:0] MS_RECIP  = 28'd137438954;
	localparam int              MS_RECIP_SH = 34;
	localparam int              DS_Q_W      = 21;

endpackage

`default_nettype wire

>>> hdl/sfd_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_ring: delay ring storage
// Simple dual-port memory with registered read and a zeroing sweep after
// reset that covers every entry once.
// ----------------------------------------------------------------------------
module sfd_ring #(
	parameter int DEPTH = 262144,
	parameter int AW    = 18,
	parameter int DW    = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	output logic          clearing
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;
	logic [AW-1:0] clr_q;
	logic          clearing_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [DW-1:0] mem_wd;

	// zeroing sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// write port shared by the sweep and the datapath
	always_comb begin
		mem_we = clearing_q | wr_en;
		mem_wa = clearing_q ? clr_q : wr_addr;
		mem_wd = clearing_q ? '0 : wr_data;
	end

	// memory array
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

	// no datapath access while the sweep runs
	assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> (!wr_en && !rd_en))
		else $error("ring accessed during clearing sweep");

	// sweep ends only after the last entry
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> ($past(clr_q) == AW'(DEPTH - 1)))
		else $error("clearing sweep ended early");

	// sweep runs once per reset
	assert property (@(posedge clk) disable iff (!arst_n)
		!clearing_q |=> !clearing_q)
		else $error("clearing sweep restarted");

endmodule

`default_nettype wire

>>> hdl/stereo_feedback_delay_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_feedback_delay_top: two-channel feedback delay line
// Echo with per-channel ring, ramped delay time, dry/wet mix and feedback.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready) carries one sample and its channel
//   index; channel 1 ends a frame and advances the write pointer and the
//   delay ramp. Output channel (out_valid/out_ready) returns one sample per
//   request, in order. Registers are written through cfg_we/cfg_index/
//   cfg_data while no request is in flight.
//   Sequence: a taken request runs the ring read-modify-write steps (two
//   multiply stages, one memory read, one write back) and the result is
//   registered as the write back finishes; no new request is taken before that.
//   Reset: registers take their reset values and the ring is zeroed by a
//   sweep over all CHANNELS * RING_DEPTH entries (262144 with the defaults);
//   in_ready stays low until the sweep is done.
//   Stall: a result waits in the output register; the next request is taken
//   and processed, and it holds in its write-back step until the output
//   register is free.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_top #(
	parameter int RING_DEPTH  = 131072,
	parameter int RAMP_FRAMES = 512,
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        sample_in,
	input  logic                                 channel,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [SAMPLE_BITS-1:0]        sample_out,
	input  logic                                 cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sfd_pkg::CFG_DATA_W-1:0]       cfg_data
);

	import sfd_pkg::*;

	localparam int DEPTH   = CHANNELS * RING_DEPTH;
	localparam int AW      = $clog2(DEPTH);
	localparam int PTR_W   = $clog2(RING_DEPTH);
	localparam int DS_W    = $clog2(RING_DEPTH + 1);
	localparam int FC_W    = (RAMP_FRAMES > 1) ? $clog2(RAMP_FRAMES) : 1;
	localparam int SB      = SAMPLE_BITS;
	localparam int PW      = SB + GAIN_X_W;
	localparam int RW      = PW - FRAC_W;
	localparam int SW      = RW + 1;
	localparam int MAG_W   = CD_W - 1;
	localparam int RAMP_SH = MAG_W + $clog2(RAMP_FRAMES);
	localparam logic [CD_W-1:0] RAMP_MUL =
		CD_W'(((64'd1 << RAMP_SH) + 64'(RAMP_FRAMES) - 64'd1) / 64'(RAMP_FRAMES));

	// round to nearest, ties up, from q.16
	function automatic logic signed [RW-1:0] rnd_q16(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = p + $signed(PW'(ROUND_Q16));
		return t[PW-1:FRAC_W];
	endfunction

	// saturate to the sample width
	function automatic logic signed [SB-1:0] sat_s(input logic signed [SW-1:0] v);
		logic signed [SB-1:0] r;
		if ((&v[SW-1:SB-1]) || !(|v[SW-1:SB-1])) begin
			r = v[SB-1:0];
		end else if (v[SW-1]) begin
			r = {1'b1, {(SB-1){1'b0}}};
		end else begin
			r = {1'b0, {(SB-1){1'b1}}};
		end
		return r;
	endfunction

	state_t state_q, state_d;

	// configuration registers
	logic [SR_W-1:0]  sr_q;
	logic [DMS_W-1:0] dms_q;
	logic [SPR_W-1:0] spr_q;
	logic [WET_W-1:0] wet_q;
	logic [FB_W-1:0]  fb_q;

	// running state
	logic signed [CD_W-1:0] cur_q;
	logic signed [CD_W-1:0] step_q;
	logic [PTR_W-1:0]       wp_q;
	logic [FC_W-1:0]        fc_q;

	// request capture
	logic signed [SB-1:0]   x_q;
	logic                   ch_q;
	logic [TOT_W-1:0]       total_q;
	logic signed [CD_W-1:0] diff_q;

	// pipeline
	logic [TOT_W+SR_W-1:0]     p_s1;
	logic signed [PW-1:0]      xd_s1;
	logic [MS_V_W+MS_R_W-1:0]  r_s2;
	logic signed [RW-1:0]      xd_s2;
	logic signed [PW-1:0]      xw_s2;
	logic [MAG_W+CD_W-1:0]     rm_s2;
	logic                      neg_s2;
	logic signed [RW-1:0]      xw_s3;
	logic signed [CD_W-1:0]    step_s3;

	// output register
	logic signed [SB-1:0] sample_out_q;
	logic                 out_valid_q;

	// control
	logic finish;
	logic rd_en;
	logic wr_en;
	logic ring_clearing;
	logic frame_end;

	// combinational datapath
	logic                   ch_in;
	logic signed [CD_W-1:0] cur_fwd;
	logic signed [TOT_W:0]  tot_w;
	logic [TOT_W-1:0]       total_in;
	logic signed [CD_W-1:0] diff_in;
	logic [WET_W-1:0]       wet_sat;
	logic signed [GAIN_X_W-1:0] dry_s;
	logic signed [GAIN_X_W-1:0] wet_s;
	logic signed [GAIN_X_W-1:0] fb_s;
	logic [MS_V_W-1:0]      p_v;
	logic [MAG_W-1:0]       diff_abs;
	logic [DS_Q_W-1:0]      dq;
	logic [DS_W-1:0]        dsamp;
	logic [DS_W:0]          rd_x;
	logic [PTR_W-1:0]       rd_idx;
	logic [AW-1:0]          base;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          wr_addr;
	logic [MAG_W-1:0]       step_mag;
	logic [CD_W-1:0]        step_u;
	logic signed [SB-1:0]   delayed;
	logic signed [PW-1:0]   fp;
	logic signed [SW-1:0]   y_sum;
	logic signed [SW-1:0]   w_sum;
	logic signed [SB-1:0]   y;
	logic signed [SB-1:0]   w;
	logic signed [CD_W-1:0] step_new;

	// ring storage
	sfd_ring #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (SB)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (delayed),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (w),
		.clearing (ring_clearing)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q  <= SR_RST;
			dms_q <= DMS_RST;
			spr_q <= SPR_RST;
			wet_q <= WET_RST;
			fb_q  <= FB_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_RATE:   sr_q  <= cfg_data[SR_W-1:0];
				REG_DELAY_MS:      dms_q <= cfg_data[DMS_W-1:0];
				REG_SPREAD_MS:     spr_q <= cfg_data[SPR_W-1:0];
				REG_WET_GAIN:      wet_q <= cfg_data[WET_W-1:0];
				REG_FEEDBACK_GAIN: fb_q  <= cfg_data[FB_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_ADDR;
			ST_ADDR: state_d = ST_WB;
			ST_WB: begin
				if (finish) begin
					state_d = (in_valid && in_ready) ? ST_MUL1 : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		finish   = 1'b0;
		rd_en    = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = !ring_clearing;
			ST_ADDR: rd_en = 1'b1;
			ST_WB: begin
				finish   = !out_valid_q || out_ready;
				in_ready = finish;
			end
			default: ;
		endcase
		wr_en = finish;
	end

	// delay total and ramp difference at request time
	// a frame end finishing in the same cycle has its delay update forwarded
	always_comb begin
		ch_in    = (CHANNELS > 1) ? channel : 1'b0;
		cur_fwd  = (finish && frame_end) ? cur_q + step_new : cur_q;
		tot_w    = ch_in ? ((TOT_W+1)'(cur_fwd) - (TOT_W+1)'({spr_q, {FRAC_W{1'b0}}}))
		                 : ((TOT_W+1)'(cur_fwd) + (TOT_W+1)'({spr_q, {FRAC_W{1'b0}}}));
		total_in = tot_w[TOT_W] ? '0 : tot_w[TOT_W-1:0];
		diff_in  = $signed({1'b0, dms_q, {FRAC_W{1'b0}}}) - cur_fwd;
	end

	// gains
	always_comb begin
		wet_sat = (wet_q > UNITY_Q16) ? UNITY_Q16 : wet_q;
		dry_s   = $signed({1'b0, UNITY_Q16 - wet_sat});
		wet_s   = $signed({1'b0, wet_sat});
		fb_s    = $signed({2'b0, fb_q});
	end

	// ms to samples, ring index and ramp step
	always_comb begin
		p_v      = p_s1[TOT_W+SR_W-1:MS_DIV_SH];
		diff_abs = MAG_W'(diff_q[CD_W-1] ? -diff_q : diff_q);
		dq       = r_s2[MS_V_W+MS_R_W-1:MS_RECIP_SH];
		if (dq == '0) begin
			dsamp = DS_W'(1);
		end else if (32'(dq) > 32'(RING_DEPTH)) begin
			dsamp = DS_W'(RING_DEPTH);
		end else begin
			dsamp = DS_W'(dq);
		end
		if ((DS_W+1)'(wp_q) >= (DS_W+1)'(dsamp)) begin
			rd_x = (DS_W+1)'(wp_q) - (DS_W+1)'(dsamp);
		end else begin
			rd_x = (DS_W+1)'(wp_q) + (DS_W+1)'(RING_DEPTH) - (DS_W+1)'(dsamp);
		end
		rd_idx   = PTR_W'(rd_x);
		base     = ch_q ? AW'(RING_DEPTH) : '0;
		rd_addr  = AW'(rd_idx) + base;
		wr_addr  = AW'(wp_q) + base;
		step_mag = MAG_W'(rm_s2 >> RAMP_SH);
		step_u   = {1'b0, step_mag};
	end

	// mix, feedback and saturation
	always_comb begin
		fp       = delayed * fb_s;
		y_sum    = SW'(xd_s2) + SW'(delayed);
		w_sum    = SW'(xw_s3) + SW'(rnd_q16(fp));
		y        = sat_s(y_sum);
		w        = sat_s(w_sum);
		step_new = (fc_q == '0) ? step_s3 : step_q;
	end

	assign frame_end = ch_q || (CHANNELS == 1);

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_q     <= sample_in;
			ch_q    <= ch_in;
			total_q <= total_in;
			diff_q  <= diff_in;
		end
		if (state_q == ST_MUL1) begin
			p_s1  <= total_q * sr_q;
			xd_s1 <= x_q * dry_s;
		end
		if (state_q == ST_MUL2) begin
			r_s2   <= p_v * MS_RECIP;
			xd_s2  <= rnd_q16(xd_s1);
			xw_s2  <= x_q * wet_s;
			rm_s2  <= diff_abs * RAMP_MUL;
			neg_s2 <= diff_q[CD_W-1];
		end
		if (state_q == ST_ADDR) begin
			xw_s3   <= rnd_q16(xw_s2);
			step_s3 <= neg_s2 ? -$signed(step_u) : $signed(step_u);
		end
		if (finish) begin
			sample_out_q <= y;
		end
	end

	// control state, pointer and ramp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cur_q       <= $signed({1'b0, DMS_RST, {FRAC_W{1'b0}}});
			step_q      <= '0;
			wp_q        <= '0;
			fc_q        <= '0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (finish && frame_end) begin
				wp_q   <= (wp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				step_q <= step_new;
				cur_q  <= cur_q + step_new;
				fc_q   <= (fc_q == FC_W'(RAMP_FRAMES - 1)) ? '0 : fc_q + 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// a taken request starts the multiply stages
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_MUL1))
		else $error("accepted request did not start processing");

	// no request is taken while the ring is being zeroed
	assert property (@(posedge clk) disable iff (!arst_n)
		ring_clearing |-> !in_ready)
		else $error("request taken during clearing sweep");

	// the write pointer moves only when a frame completes
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(wp_q) |-> $past(finish && frame_end))
		else $error("write pointer moved outside frame end");

	// a result appears only out of the write-back step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WB))
		else $error("result raised outside write back");

endmodule

`default_nettype wire

>>> bench/sfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker: echo predictor and result scoreboard
// Watches the register port and both request channels of the stereo feedback
// delay, predicts every output sample from its own copy of the rings, the
// ramp and the registers, and compares each returned sample in order.
// ----------------------------------------------------------------------------
module sfd_checker #(
	parameter int RING_DEPTH  = 131072,
	parameter int RAMP_FRAMES = 512,
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic signed [SAMPLE_BITS-1:0]  sample_in,
	input  logic                           channel,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic signed [SAMPLE_BITS-1:0]  sample_out,
	input  logic                           cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                    in_flight,
	output int unsigned                    mismatches
);
	import sfd_pkg::*;

	localparam longint SAMPLE_HI  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_LO  = -SAMPLE_HI - 1;
	localparam longint Q16_ONE    = longint'(1) <<< FRAC_W;
	localparam longint MS_PER_SEC = 1000;
	localparam int     PRINT_CAP  = 200;

	// predicted state of the block
	logic signed [SAMPLE_BITS-1:0] echo_ring [0:CHANNELS*RING_DEPTH-1];
	int unsigned                   wr_ptr;
	longint                        cur_delay_q16;
	longint                        ramp_inc;
	int unsigned                   ramp_frame;

	// register copies
	logic [SR_W-1:0]  rate_hz;
	logic [DMS_W-1:0] target_ms;
	logic [SPR_W-1:0] spread;
	logic [WET_W-1:0] wet_reg;
	logic [FB_W-1:0]  fb_reg;

	// samples predicted and not yet returned, oldest first
	logic signed [SAMPLE_BITS-1:0] echo_expected [$];
	int unsigned                   result_cnt;

	// x * gain in q.16, rounded half up
	function automatic longint gain_q16(input longint a, input longint g);
		longint p;
		p = a * g + 32768;
		return p >>> FRAC_W;
	endfunction

	function automatic longint clip_sample(input longint v);
		if (v > SAMPLE_HI)
			return SAMPLE_HI;
		if (v < SAMPLE_LO)
			return SAMPLE_LO;
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("[%0t] result %0d: %s", $time, result_cnt, msg);
		mismatches++;
	endtask

	// one request: read the tap, mix, write back, advance the frame
	task automatic predict_echo(input logic signed [SAMPLE_BITS-1:0] x_in, input logic ch_in,
			output logic signed [SAMPLE_BITS-1:0] y_out);
		longint          x;
		longint          wet;
		longint          dry;
		longint          total;
		longint          delayed;
		longint          y;
		longint          fed;
		longint unsigned nsamp;
		int unsigned     ch;
		int unsigned     rd;
		int unsigned     base;
		x = x_in;
		ch = (CHANNELS > 1) ? int'(ch_in) : 0;
		wet = (wet_reg > UNITY_Q16) ? longint'(UNITY_Q16) : longint'(wet_reg);
		dry = longint'(UNITY_Q16) - wet;

		// spread adds on the even channel, subtracts on the odd one
		total = cur_delay_q16;
		if (ch == 1)
			total = total - longint'(spread) * Q16_ONE;
		else
			total = total + longint'(spread) * Q16_ONE;
		if (total < 0)
			total = 0;

		// ms to samples, kept inside the ring
		nsamp = (longint'(total) * longint'(rate_hz)) / (MS_PER_SEC * Q16_ONE);
		if (nsamp < 1)
			nsamp = 1;
		if (nsamp > RING_DEPTH)
			nsamp = RING_DEPTH;
		rd = int'((longint'(wr_ptr) + RING_DEPTH - longint'(nsamp)) % RING_DEPTH);
		base = ch * RING_DEPTH;

		delayed = echo_ring[base + rd];
		y = clip_sample(gain_q16(x, dry) + delayed);
		fed = clip_sample(gain_q16(x, wet) + gain_q16(delayed, longint'(fb_reg)));
		echo_ring[base + wr_ptr] = fed[SAMPLE_BITS-1:0];

		// frame end: pointer and delay ramp move on
		if (ch == CHANNELS - 1) begin
			wr_ptr = (wr_ptr + 1) % RING_DEPTH;
			if (ramp_frame == 0)
				ramp_inc = (longint'(target_ms) * Q16_ONE - cur_delay_q16) / RAMP_FRAMES;
			cur_delay_q16 = cur_delay_q16 + ramp_inc;
			ramp_frame = (ramp_frame + 1) % RAMP_FRAMES;
		end
		y_out = y[SAMPLE_BITS-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic signed [SAMPLE_BITS-1:0] y_pred;
		logic signed [SAMPLE_BITS-1:0] y_old;
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS * RING_DEPTH; i++)
				echo_ring[i] = '0;
			wr_ptr = 0;
			rate_hz = SR_RST;
			target_ms = DMS_RST;
			spread = SPR_RST;
			wet_reg = WET_RST;
			fb_reg = FB_RST;
			cur_delay_q16 = longint'(DMS_RST) * Q16_ONE;
			ramp_inc = 0;
			ramp_frame = 0;
			echo_expected.delete();
			result_cnt = 0;
			mismatches = 0;
			in_flight <= 0;
		end else begin
			// register writes, only ever while idle
			if (cfg_we) begin
				case (cfg_index)
					REG_SAMPLE_RATE:   rate_hz = cfg_data[SR_W-1:0];
					REG_DELAY_MS:      target_ms = cfg_data[DMS_W-1:0];
					REG_SPREAD_MS:     spread = cfg_data[SPR_W-1:0];
					REG_WET_GAIN:      wet_reg = cfg_data[WET_W-1:0];
					REG_FEEDBACK_GAIN: fb_reg = cfg_data[FB_W-1:0];
					default: ;
				endcase
			end

			// returned sample against the oldest prediction
			if (out_valid && out_ready) begin
				if (echo_expected.size() == 0) begin
					report_mismatch($sformatf("sample_out %0d with no request waiting",
						sample_out));
				end else begin
					y_old = echo_expected.pop_front();
					if (sample_out !== y_old)
						report_mismatch($sformatf("sample_out %0d, predicted %0d",
							sample_out, y_old));
				end
				result_cnt++;
			end

			// accepted request
			if (in_valid && in_ready) begin
				predict_echo(sample_in, channel, y_pred);
				echo_expected.push_back(y_pred);
			end
			in_flight <= echo_expected.size();
		end
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the stereo feedback delay
// Drives sample requests and register settings with random idle bursts on
// both channels; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
	import sfd_pkg::*;

	localparam int RING_DEPTH  = 131072;
	localparam int RAMP_FRAMES = 512;
	localparam int CHANNELS    = 2;
	localparam int SAMPLE_BITS = 24;

	// reset sweep of the ring plus slow handshakes, several times over
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int          TAIL_CYCLES = 8;

	localparam logic [CFG_IDX_W-1:0]         REG_SPARE  = 3'd7;
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] sample_in = '0;
	logic                          channel = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [CFG_DATA_W-1:0]         cfg_data = '0;

	int unsigned in_flight;
	int unsigned mismatches;
	bit          idle_on = 1'b1;
	int unsigned cycle_cnt = 0;
	int unsigned stall_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	stereo_feedback_delay_top #(
		.RING_DEPTH (RING_DEPTH),
		.RAMP_FRAMES(RAMP_FRAMES),
		.CHANNELS   (CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.channel   (channel),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sfd_checker #(
		.RING_DEPTH (RING_DEPTH),
		.RAMP_FRAMES(RAMP_FRAMES),
		.CHANNELS   (CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.channel   (channel),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_flight (in_flight),
		.mismatches(mismatches)
	);

	// output back-pressure in random bursts
	always @(posedge clk) begin
		if (!idle_on) begin
			out_ready <= 1'b1;
			stall_left = 0;
		end else if (stall_left != 0) begin
			stall_left--;
		end else if (out_ready && $urandom_range(0, 2) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(1, 19) - 1;
		end else begin
			out_ready <= 1'b1;
			stall_left = $urandom_range(0, 30);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d requests outstanding", cycle_cnt, in_flight);
			$display("Mismatches found");
			$finish;
		end
	end

	// one sample request, with an optional idle burst in front
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic ch);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= value;
		channel <= ch;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// wait until every request has come back and the block is quiet
	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(data);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input int unsigned rate, input int unsigned dms,
			input int unsigned spr, input int unsigned wet, input int unsigned fb);
		write_reg(REG_SAMPLE_RATE, rate);
		write_reg(REG_DELAY_MS, dms);
		write_reg(REG_SPREAD_MS, spr);
		write_reg(REG_WET_GAIN, wet);
		write_reg(REG_FEEDBACK_GAIN, fb);
	endtask

	// half full-scale noise, the rest extremes and quiet passages
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		int v;
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3, 4: begin
				v = $urandom_range(0, 511);
				return SAMPLE_BITS'(v - 256);
			end
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// mostly whole frames, with a share of out-of-order channels
	task automatic run_frames(input int unsigned n_items);
		logic next_ch;
		logic ch;
		next_ch = 1'b0;
		for (int unsigned i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 9) == 0)
				ch = 1'($urandom_range(0, 1));
			else
				ch = next_ch;
			send_sample(pick_sample(), ch);
			next_ch = ~ch;
		end
	endtask

	initial begin
		int unsigned n_items;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: extremes and rounding around zero
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b1);
		send_sample('0, 1'b0);
		send_sample(-1, 1'b1);
		send_sample(1, 1'b0);
		send_sample(SAMPLE_MIN, 1'b1);
		drain_block();

		// zero sample rate gives a one-sample tap; wet above unity, full feedback
		apply_setting(0, 250, 0, 131071, 65535);
		repeat (3) begin
			send_sample(SAMPLE_MAX, 1'b0);
			send_sample(SAMPLE_MAX, 1'b1);
		end
		repeat (2) begin
			send_sample(SAMPLE_MIN, 1'b0);
			send_sample(SAMPLE_MIN, 1'b1);
		end
		drain_block();

		// spread beyond the delay: left tap past the ring, right tap below zero
		apply_setting(192000, 250, 500, 65536, 0);
		repeat (4) begin
			send_sample(pick_sample(), 1'b0);
			send_sample(pick_sample(), 1'b1);
		end
		drain_block();

		// random phases over several settings
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin
					apply_setting($urandom_range(0, 400), $urandom_range(0, 2047),
						$urandom_range(0, 511), $urandom_range(0, 65536), $urandom_range(0, 65535));
					n_items = 300;
				end
				1: begin
					apply_setting(8000, 0, $urandom_range(0, 511), $urandom_range(0, 65536), 65535);
					n_items = 250;
				end
				2: begin
					idle_on = 1'b0;
					apply_setting($urandom_range(0, 1000), $urandom_range(0, 2047),
						$urandom_range(0, 511), $urandom_range(0, 131071), $urandom_range(0, 65535));
					n_items = 250;
				end
				3: begin
					idle_on = 1'b1;
					write_reg(REG_SPARE, $urandom_range(0, 262143));
					apply_setting(262143, 2047, 511, 0, 65535);
					n_items = 100;
				end
				4: begin
					apply_setting($urandom_range(0, 262143), $urandom_range(0, 2047),
						$urandom_range(0, 511), $urandom_range(0, 131071), $urandom_range(0, 65535));
					n_items = 200;
				end
				5: begin
					apply_setting(0, $urandom_range(0, 2047), $urandom_range(0, 511),
						$urandom_range(0, 65536), $urandom_range(0, 65535));
					n_items = 300;
				end
				default: begin
					// last stretch runs at full rate
					idle_on = 1'b0;
					apply_setting($urandom_range(1, 600), 0, $urandom_range(0, 100),
						$urandom_range(0, 65536), $urandom_range(30000, 65535));
					n_items = 350;
				end
			endcase
			run_frames(n_items);
			drain_block();
		end

		if (mismatches == 0 && in_flight == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> stereo_feedback_delay_top.f
hdl/sfd_pkg.sv
hdl/sfd_ring.sv
hdl/stereo_feedback_delay_top.sv
bench/sfd_checker.sv
bench/tb_top.sv
